// ===== hw/rtl/remote_command_byte_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the remote command byte decoder
// Short forms for same-cycle and next-cycle checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef REMOTE_COMMAND_BYTE_DECODER_UNIT_ASSERT_SVH
`define REMOTE_COMMAND_BYTE_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Remote command byte decoder package
// Byte codes, key codes, turn modes and sizes shared by the decoder.
// ----------------------------------------------------------------------------
package rcbd_pkg;

   localparam int FRAME_LEN_DEFAULT = 50;

   // Command bytes.
   localparam logic [7:0] BYTE_MODE_POSE = 8'h4B;
   localparam logic [7:0] BYTE_MODE_DIR  = 8'h4A;
   localparam logic [7:0] BYTE_MODE_IDLE = 8'h49;
   localparam logic [7:0] BYTE_STAND     = 8'h58;
   localparam logic [7:0] BYTE_ACTION    = 8'h59;

   // Frame bytes.
   localparam logic [7:0] BYTE_OPEN      = 8'h7B;
   localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
   localparam logic [7:0] BYTE_REPORT    = 8'h50;
   localparam logic [7:0] BYTE_ZERO      = 8'h30;

   // Direction and pose letters.
   localparam logic [7:0] BYTE_DIR_BASE  = 8'h40;
   localparam logic [7:0] BYTE_LETTER_A  = 8'h41;
   localparam logic [7:0] BYTE_LETTER_C  = 8'h43;
   localparam logic [7:0] BYTE_LETTER_E  = 8'h45;
   localparam logic [7:0] BYTE_LETTER_G  = 8'h47;
   localparam logic [7:0] BYTE_LETTER_H  = 8'h48;
   localparam logic [7:0] BYTE_RAW_DIR_MAX = 8'h08;

   localparam logic [2:0] POSE_NONE = 3'd0;
   localparam logic [2:0] POSE_ONE  = 3'd1;
   localparam logic [2:0] POSE_3    = 3'd3;
   localparam logic [2:0] POSE_5    = 3'd5;
   localparam logic [2:0] POSE_7    = 3'd7;

   // Turn modes.
   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_DIRECTION = 2'd1;
   localparam logic [1:0] MODE_POSE      = 2'd2;

   // Key codes.
   localparam logic [4:0] KEY_NONE     = 5'd0;
   localparam logic [4:0] KEY_STOPPED  = 5'd4;
   localparam logic [4:0] KEY_ACTION   = 5'd14;
   localparam logic [4:0] KEY_IDLE     = 5'd15;
   localparam logic [4:0] KEY_STANDING = 5'd16;

   // Positions inside a frame.
   localparam int POS_ID     = 1;
   localparam int POS_FOURTH = 3;

   // Saturation bounds of the velocity accumulator.
   localparam int ACC_WIDE_W = 38;
   localparam logic signed [ACC_WIDE_W-1:0] ACC_MAX = 38'sd2147483647;
   localparam logic signed [ACC_WIDE_W-1:0] ACC_MIN = -38'sd2147483647;

   typedef struct packed {
      logic [1:0]         turn_mode;
      logic [3:0]         direction;
      logic [2:0]         pose;
      logic               key_valid;
      logic [4:0]         key_code;
      logic               standing;
      logic               app_takeover;
      logic               report_request;
      logic               velocity_valid;
      logic signed [31:0] velocity;
   } rsp_type;

endpackage

// ===== hw/rtl/remote_command_byte_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// Remote command byte decoder
// Decodes received remote-control bytes into turn mode, direction, pose,
// key presses, standing toggle, source takeover, report requests and velocity frames.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one received byte per word together with the
// start-up flag. Every accepted word yields exactly one word on the rsp
// channel, in order.
// An accepted word is first registered in the input register; its decode
// against the held state is then registered in the result register, which
// drives rsp. The held state is updated together with the result register.
// One word per cycle is sustained while rsp_stall is low: the input register and the result
// register advance together, and the decode is a single pass of logic
// between them with a short 38-bit shift-and-add for the decimal accumulator.
// When rsp_stall is high with rsp valid, the result register holds; the input
// register takes one more word only if empty, and req_stall is high once full.
// Synchronous reset clears both valid flags, the turn mode, held direction
// and pose, standing flag, source selection and all frame state.
// ----------------------------------------------------------------------------
`include "remote_command_byte_decoder_unit_assert.svh"

module remote_command_byte_decoder_unit #(
   parameter int FRAME_LEN = rcbd_pkg::FRAME_LEN_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_startup_done,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_turn_mode,
   output logic [3:0]         rsp_direction,
   output logic [2:0]         rsp_pose,
   output logic               rsp_key_valid,
   output logic [4:0]         rsp_key_code,
   output logic               rsp_standing,
   output logic               rsp_app_takeover,
   output logic               rsp_report_request,
   output logic               rsp_velocity_valid,
   output logic signed [31:0] rsp_velocity
);

   localparam int IdxW = $clog2(FRAME_LEN + 1);
   localparam int AccW = rcbd_pkg::ACC_WIDE_W;

   // Handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ready, s1_ready, s1_fire;

   // Input register
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;

   // Decoder state
   logic [1:0]          mode_ff, mode_in;
   logic [3:0]          direction_ff, direction_in;
   logic [2:0]          pose_ff, pose_in;
   logic                standing_ff, standing_in;
   logic                app_sel_ff, app_sel_in;
   logic                frame_open_ff, frame_open_in;
   logic [IdxW-1:0]     frame_index_ff, frame_index_in;
   logic [7:0]          frame_id_ff, frame_id_in;
   logic [7:0]          frame_fourth_ff, frame_fourth_in;
   logic signed [31:0]  acc_ff, acc_in;

   // Result register
   rcbd_pkg::rsp_type rsp_ff, rsp_in;

   // Accumulator step
   logic signed [AccW-1:0] acc_ext, acc_wide, digit_term;
   logic signed [AccW-1:0] acc_sat;
   logic [7:0]             dir_offset;

   assign rsp_ready   = !rsp_valid_ff || !rsp_stall;
   assign s1_ready    = !s1_valid_ff || rsp_ready;
   assign s1_fire     = s1_valid_ff && rsp_ready;
   assign req_stall   = !s1_ready;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = rsp_ready ? s1_valid_ff : rsp_valid_ff;

   // acc * 10 + (byte - '0') as shifts and adds, then clamped.
   assign acc_ext    = {{(AccW-32){acc_ff[31]}}, acc_ff};
   assign digit_term = $signed({{(AccW-8){1'b0}}, s1_byte_ff})
                       - $signed({{(AccW-8){1'b0}}, rcbd_pkg::BYTE_ZERO});
   assign acc_wide   = (acc_ext <<< 3) + (acc_ext <<< 1) + digit_term;
   assign dir_offset = s1_byte_ff - rcbd_pkg::BYTE_DIR_BASE;

   always_comb begin
      if (acc_wide > rcbd_pkg::ACC_MAX) begin
         acc_sat = rcbd_pkg::ACC_MAX;
      end else if (acc_wide < rcbd_pkg::ACC_MIN) begin
         acc_sat = rcbd_pkg::ACC_MIN;
      end else begin
         acc_sat = acc_wide;
      end
   end

   always_comb begin
      mode_in         = mode_ff;
      direction_in    = direction_ff;
      pose_in         = pose_ff;
      standing_in     = standing_ff;
      app_sel_in      = app_sel_ff;
      frame_open_in   = frame_open_ff;
      frame_index_in  = frame_index_ff;
      frame_id_in     = frame_id_ff;
      frame_fourth_in = frame_fourth_ff;
      acc_in          = acc_ff;
      rsp_in          = '0;

      if (!app_sel_ff && s1_start_ff) begin
         app_sel_in          = 1'b1;
         rsp_in.app_takeover = 1'b1;
      end

      if (s1_byte_ff == rcbd_pkg::BYTE_MODE_POSE) begin
         mode_in = rcbd_pkg::MODE_POSE;
      end else if (s1_byte_ff == rcbd_pkg::BYTE_MODE_DIR) begin
         mode_in = rcbd_pkg::MODE_DIRECTION;
      end else if (s1_byte_ff == rcbd_pkg::BYTE_MODE_IDLE) begin
         mode_in          = rcbd_pkg::MODE_IDLE;
         rsp_in.key_valid = 1'b1;
         rsp_in.key_code  = rcbd_pkg::KEY_IDLE;
      end

      // The standing toggle reports the key of the new state.
      if (s1_byte_ff == rcbd_pkg::BYTE_STAND) begin
         standing_in      = !standing_ff;
         rsp_in.key_valid = 1'b1;
         rsp_in.key_code  = standing_ff ? rcbd_pkg::KEY_STOPPED
                                        : rcbd_pkg::KEY_STANDING;
      end
      if (s1_byte_ff == rcbd_pkg::BYTE_ACTION) begin
         rsp_in.key_valid = 1'b1;
         rsp_in.key_code  = rcbd_pkg::KEY_ACTION;
      end

      if (mode_in == rcbd_pkg::MODE_DIRECTION) begin
         if (s1_byte_ff >= rcbd_pkg::BYTE_LETTER_A
             && s1_byte_ff <= rcbd_pkg::BYTE_LETTER_H) begin
            direction_in = dir_offset[3:0];
         end else if (s1_byte_ff <= rcbd_pkg::BYTE_RAW_DIR_MAX) begin
            direction_in = s1_byte_ff[3:0];
         end else begin
            direction_in = '0;
         end
      end else if (mode_in == rcbd_pkg::MODE_POSE) begin
         unique case (s1_byte_ff)
            rcbd_pkg::BYTE_LETTER_A: pose_in = rcbd_pkg::POSE_ONE;
            rcbd_pkg::BYTE_LETTER_C: pose_in = rcbd_pkg::POSE_3;
            rcbd_pkg::BYTE_LETTER_E: pose_in = rcbd_pkg::POSE_5;
            rcbd_pkg::BYTE_LETTER_G: pose_in = rcbd_pkg::POSE_7;
            default:                 pose_in = rcbd_pkg::POSE_NONE;
         endcase
      end

      if (s1_byte_ff == rcbd_pkg::BYTE_OPEN) begin
         frame_open_in = 1'b1;
      end

      // A closing brace ends the frame even when none was open.
      if (s1_byte_ff == rcbd_pkg::BYTE_CLOSE) begin
         if (frame_fourth_ff == rcbd_pkg::BYTE_REPORT) begin
            rsp_in.report_request = 1'b1;
         end else if (frame_id_ff == rcbd_pkg::BYTE_ZERO) begin
            rsp_in.velocity_valid = 1'b1;
            rsp_in.velocity       = acc_ff;
         end
         frame_open_in   = 1'b0;
         frame_index_in  = '0;
         frame_id_in     = '0;
         frame_fourth_in = '0;
         acc_in          = '0;
      end else if (frame_open_in && frame_index_ff < IdxW'(FRAME_LEN)) begin
         if (frame_index_ff == IdxW'(rcbd_pkg::POS_ID)) begin
            frame_id_in = s1_byte_ff;
         end
         if (frame_index_ff == IdxW'(rcbd_pkg::POS_FOURTH)) begin
            frame_fourth_in = s1_byte_ff;
         end
         if (frame_index_ff >= IdxW'(rcbd_pkg::POS_FOURTH)) begin
            acc_in = acc_sat[31:0];
         end
         frame_index_in = frame_index_ff + IdxW'(1);
      end

      rsp_in.turn_mode = mode_in;
      rsp_in.direction = direction_in;
      rsp_in.pose      = pose_in;
      rsp_in.standing  = standing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_byte_ff  <= req_rx_byte;
         s1_start_ff <= req_startup_done;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= rcbd_pkg::MODE_IDLE;
         direction_ff    <= '0;
         pose_ff         <= rcbd_pkg::POSE_NONE;
         standing_ff     <= 1'b0;
         app_sel_ff      <= 1'b0;
         frame_open_ff   <= 1'b0;
         frame_index_ff  <= '0;
         frame_id_ff     <= '0;
         frame_fourth_ff <= '0;
         acc_ff          <= '0;
      end else if (s1_fire) begin
         mode_ff         <= mode_in;
         direction_ff    <= direction_in;
         pose_ff         <= pose_in;
         standing_ff     <= standing_in;
         app_sel_ff      <= app_sel_in;
         frame_open_ff   <= frame_open_in;
         frame_index_ff  <= frame_index_in;
         frame_id_ff     <= frame_id_in;
         frame_fourth_ff <= frame_fourth_in;
         acc_ff          <= acc_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_turn_mode      = rsp_ff.turn_mode;
   assign rsp_direction      = rsp_ff.direction;
   assign rsp_pose           = rsp_ff.pose;
   assign rsp_key_valid      = rsp_ff.key_valid;
   assign rsp_key_code       = rsp_ff.key_code;
   assign rsp_standing       = rsp_ff.standing;
   assign rsp_app_takeover   = rsp_ff.app_takeover;
   assign rsp_report_request = rsp_ff.report_request;
   assign rsp_velocity_valid = rsp_ff.velocity_valid;
   assign rsp_velocity       = rsp_ff.velocity;

   `RCBD_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_valid && !req_stall, s1_valid_ff, "accepted word did not reach the input register")
   `RCBD_ASSERT_NEXT(a_drain_empties_rsp, clock, reset, rsp_valid_ff && !rsp_stall && !s1_valid_ff, !rsp_valid_ff, "result word was repeated after handoff")
   `RCBD_ASSERT_NOW(a_index_bound, clock, reset, 1'b1, frame_index_ff <= IdxW'(FRAME_LEN), "frame index ran past the frame length")
   `RCBD_ASSERT_NOW(a_single_frame_event, clock, reset, rsp_valid_ff, !(rsp_ff.report_request && rsp_ff.velocity_valid), "report and velocity issued by one word")
   `RCBD_ASSERT_NOW(a_key_code_quiet, clock, reset, rsp_valid_ff && !rsp_ff.key_valid, rsp_ff.key_code == rcbd_pkg::KEY_NONE, "key code set without a key")

endmodule
